>>> sv/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared constants, types and codes for the text console with scrollback.
// ----------------------------------------------------------------------------
package tcs_pkg;

  // Screen and store geometry
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int BUFFER_ROWS    = 64;
  localparam int STORE_CELLS    = BUFFER_ROWS * SCREEN_COLUMNS;
  localparam int SCREEN_CELLS   = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int LAST_TOP       = (STORE_CELLS > SCREEN_CELLS) ?
                                  STORE_CELLS - SCREEN_CELLS : 0;
  // Fold copies the last screen minus one row to the front of the store
  localparam int FOLD_CELLS     = SCREEN_CELLS - SCREEN_COLUMNS;
  localparam int FOLD_SRC       = STORE_CELLS + SCREEN_COLUMNS - SCREEN_CELLS;
  localparam int FOLLOW_STEPS   = BUFFER_ROWS + 2;

  // Field widths
  localparam int POS_W  = 13;
  localparam int ROW_W  = $clog2(BUFFER_ROWS + 1);
  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int STEP_W = $clog2(FOLLOW_STEPS + 1);
  localparam int CELL_W = 16;

  // Characters and attribute
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'd7;

  // Transaction modes
  typedef enum logic [1:0] {
    MODE_PUT    = 2'd0,
    MODE_FWD    = 2'd1,
    MODE_BACK   = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_FOLLOW,
    ST_COPY,
    ST_FOLD_FIN,
    ST_BLANK,
    ST_RESULT
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_PUT,
    OP_FOLLOW,
    OP_COPY,
    OP_FOLD_FIN,
    OP_BLANK,
    OP_SCROLL,
    OP_READ,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic latch;
    logic cnt_clr;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  clr_done;
    logic  copy_done;
    logic  blank_done;
    logic  overflow;
    logic  follow_exit;
    logic  out_free;
  } status_t;

endpackage

>>> sv/tcs_in_if.sv
// ----------------------------------------------------------------------------
// tcs_in_if
// Input channel: valid/ready handshake with one console command.
// ----------------------------------------------------------------------------
interface tcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  char_code;
  logic [12:0] read_index;

  modport source (output valid, mode, char_code, read_index, input ready);
  modport sink   (input valid, mode, char_code, read_index, output ready);
endinterface

>>> sv/tcs_out_if.sv
// ----------------------------------------------------------------------------
// tcs_out_if
// Result channel: valid/ready handshake with cursor, view and read cell.
// ----------------------------------------------------------------------------
interface tcs_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] cursor_pos;
  logic [12:0] display_start;
  logic [7:0]  read_char;
  logic [7:0]  read_attr;

  modport source (output valid, cursor_pos, display_start, read_char, read_attr,
                  input ready);
  modport sink   (input valid, cursor_pos, display_start, read_char, read_attr,
                  output ready);
endinterface

>>> sv/text_console_scrollback.sv
// ----------------------------------------------------------------------------
// text_console_scrollback
// Text-mode console with a scrollback cell store, cursor and view tracking.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake        Payload
//  in_ch     in    valid / ready    mode, char_code, read_index
//  out_ch    out   valid / ready    cursor_pos, display_start, read_char, read_attr
//  cfg_*     in    cfg_we           cfg_wdata (attribute byte)
//
// One transaction at a time. Scroll and read go from dispatch to the result, which
// waits for out_ch. A character steps through follow; each follow step blanks one
// line through the single RAM write port. A store fold copies cells at one cell a
// cycle and then blanks a line. After reset a clearing pass writes all 5120
// cells, one a cycle, with in_ch.ready low. A result waiting on out_ch does not
// block the next accept.
module text_console_scrollback (
  input  logic       clk,
  input  logic       rst_n,
  tcs_in_if.sink     in_ch,
  tcs_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import tcs_pkg::*;

  cmd_t    cmd;
  status_t sts;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_ch.mode),
    .in_char_code      (in_ch.char_code),
    .in_read_index     (in_ch.read_index),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_cursor_pos    (out_ch.cursor_pos),
    .out_display_start (out_ch.display_start),
    .out_read_char     (out_ch.read_char),
    .out_read_attr     (out_ch.read_attr)
  );

  // One transaction in flight: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("accepted a second transaction while busy");

  // Reported cursor never points past the store
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.cursor_pos < POS_W'(STORE_CELLS)))
    else $error("cursor out of store");

  // View top never passes the last full screen
  a_view_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.display_start <= POS_W'(LAST_TOP)))
    else $error("view start out of range");

endmodule

>>> sv/tcs_ram.sv
// ----------------------------------------------------------------------------
// tcs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/tcs_ctrl.sv
// ----------------------------------------------------------------------------
// tcs_ctrl
// Sequencer: clearing pass, command dispatch, fold, follow-scroll loop.
// ----------------------------------------------------------------------------
module tcs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcs_pkg::status_t sts,
  output tcs_pkg::cmd_t    cmd
);
  import tcs_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.op      = OP_NONE;
    cmd.latch   = 1'b0;
    cmd.cnt_clr = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.cnt_clr = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.mode)
          MODE_PUT: begin
            cmd.op    = OP_PUT;
            state_nxt = ST_FOLLOW;
          end
          MODE_FWD, MODE_BACK: begin
            cmd.op    = OP_SCROLL;
            state_nxt = ST_RESULT;
          end
          MODE_READ: begin
            cmd.op    = OP_READ;
            state_nxt = ST_RESULT;
          end
          default: state_nxt = ST_RESULT;
        endcase
      end
      ST_FOLLOW: begin
        cmd.op      = OP_FOLLOW;
        cmd.cnt_clr = 1'b1;
        if (sts.overflow)         state_nxt = ST_COPY;
        else if (sts.follow_exit) state_nxt = ST_RESULT;
        else                      state_nxt = ST_BLANK;
      end
      ST_COPY: begin
        cmd.op = OP_COPY;
        if (sts.copy_done) state_nxt = ST_FOLD_FIN;
      end
      ST_FOLD_FIN: begin
        cmd.op      = OP_FOLD_FIN;
        cmd.cnt_clr = 1'b1;
        state_nxt   = ST_BLANK;
      end
      ST_BLANK: begin
        cmd.op = OP_BLANK;
        if (sts.blank_done) state_nxt = ST_FOLLOW;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.op    = OP_RESULT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> sv/tcs_dp.sv
// ----------------------------------------------------------------------------
// tcs_dp
// Datapath: cursor, view, wrap flag, cell store, counters and result register.
// ----------------------------------------------------------------------------
module tcs_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcs_pkg::cmd_t         cmd,
  output tcs_pkg::status_t      sts,
  input  logic [1:0]            in_mode,
  input  logic [7:0]            in_char_code,
  input  logic [12:0]           in_read_index,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [12:0]           out_cursor_pos,
  output logic [12:0]           out_display_start,
  output logic [7:0]            out_read_char,
  output logic [7:0]            out_read_attr
);
  import tcs_pkg::*;

  localparam int AW = $clog2(STORE_CELLS);

  // Control state
  logic [POS_W-1:0]  cursor_r, cursor_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [POS_W-1:0]  view_r, view_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [7:0]        attr_r;
  logic [POS_W-1:0]  cnt_r;
  logic [STEP_W-1:0] steps_r;
  logic              out_valid_r;

  // Latched command payload
  mode_t             mode_r;
  logic [7:0]        char_r;
  logic [POS_W-1:0]  idx_r;

  // Result payload
  logic [POS_W-1:0]  res_cursor_r, res_view_r;
  logic [7:0]        res_char_r, res_attr_r;

  // Memory port
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  // View arithmetic
  logic [POS_W:0]    view_end;
  logic [POS_W-1:0]  newest, oldest, newest_next, view_dec;
  logic [POS_W-1:0]  fwd_view, bwd_view;
  logic              visible, idx_ok, is_nl, is_bs;
  logic [POS_W:0]    blank_pos;

  tcs_ram #(.WIDTH(CELL_W), .DEPTH(STORE_CELLS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign view_end    = {1'b0, view_r} + (POS_W+1)'(SCREEN_CELLS);
  assign newest      = POS_W'(row_r) * POS_W'(SCREEN_COLUMNS);
  assign newest_next = newest + POS_W'(SCREEN_COLUMNS);
  assign oldest      = !wrapped_r ? '0 :
                       (newest_next == POS_W'(STORE_CELLS)) ? '0 : newest_next;
  assign view_dec    = (view_r >= POS_W'(SCREEN_COLUMNS)) ?
                       view_r - POS_W'(SCREEN_COLUMNS) : '0;
  assign visible     = ({1'b0, cursor_r} < view_end) && (cursor_r >= view_r);
  assign idx_ok      = idx_r < POS_W'(STORE_CELLS);
  assign is_nl       = char_r == CH_NEWLINE;
  assign is_bs       = char_r == CH_BACKSPACE;
  assign blank_pos   = {1'b0, cursor_r} + {1'b0, cnt_r};

  // Forward scroll target
  always_comb begin
    fwd_view = view_r;
    if (!wrapped_r) begin
      if ({1'b0, newest} >= view_end) fwd_view = view_r + POS_W'(SCREEN_COLUMNS);
    end else if (view_end - (POS_W+1)'(SCREEN_COLUMNS) != {1'b0, newest}) begin
      if (view_end == (POS_W+1)'(STORE_CELLS)) fwd_view = '0;
      else                                     fwd_view = view_r + POS_W'(SCREEN_COLUMNS);
    end
  end

  // Backward scroll target
  always_comb begin
    bwd_view = view_r;
    if (!wrapped_r) begin
      if (view_r != '0) bwd_view = view_dec;
    end else if (view_r != oldest) begin
      if (cursor_r >= POS_W'(LAST_TOP)) begin
        if (view_r != '0) bwd_view = view_dec;
      end else if (view_r == '0) begin
        bwd_view = POS_W'(LAST_TOP);
      end else begin
        bwd_view = view_dec;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts.mode        = mode_r;
    sts.clr_done    = cnt_r == POS_W'(STORE_CELLS - 1);
    sts.copy_done   = cnt_r == POS_W'(FOLD_CELLS);
    sts.blank_done  = cnt_r == POS_W'(SCREEN_COLUMNS - 1);
    sts.overflow    = row_r == ROW_W'(BUFFER_ROWS);
    sts.follow_exit = visible || (steps_r == STEP_W'(FOLLOW_STEPS)) ||
                      (fwd_view == view_r);
    sts.out_free    = !out_valid_r || out_ready;
  end

  // Cursor, view and wrap updates
  always_comb begin
    cursor_nxt  = cursor_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    view_nxt    = view_r;
    wrapped_nxt = wrapped_r;
    case (cmd.op)
      OP_PUT: begin
        if (is_nl) begin
          cursor_nxt = cursor_r - POS_W'(col_r) + POS_W'(SCREEN_COLUMNS);
          row_nxt    = row_r + 1'b1;
          col_nxt    = '0;
        end else if (is_bs) begin
          if (cursor_r != '0) begin
            cursor_nxt = cursor_r - 1'b1;
            if (col_r == '0) begin
              row_nxt = row_r - 1'b1;
              col_nxt = COL_W'(SCREEN_COLUMNS - 1);
            end else begin
              col_nxt = col_r - 1'b1;
            end
          end
        end else begin
          cursor_nxt = cursor_r + 1'b1;
          if (col_r == COL_W'(SCREEN_COLUMNS - 1)) begin
            row_nxt = row_r + 1'b1;
            col_nxt = '0;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      OP_FOLLOW: begin
        if (!sts.overflow && !visible && steps_r != STEP_W'(FOLLOW_STEPS)) begin
          view_nxt = fwd_view;
        end
      end
      OP_FOLD_FIN: begin
        // Overflow only happens at column zero of the row past the store
        cursor_nxt  = POS_W'(SCREEN_CELLS - SCREEN_COLUMNS);
        row_nxt     = ROW_W'(SCREEN_ROWS - 1);
        col_nxt     = '0;
        view_nxt    = '0;
        wrapped_nxt = 1'b1;
      end
      OP_SCROLL: begin
        view_nxt = (mode_r == MODE_FWD) ? fwd_view : bwd_view;
      end
      default: ;
    endcase
  end

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = {attr_r, CH_SPACE};
    case (cmd.op)
      OP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = {RESET_ATTR, CH_SPACE};
      end
      OP_PUT: begin
        if (is_nl) begin
          mem_we = 1'b0;
        end else if (is_bs) begin
          mem_we    = cursor_r != '0;
          mem_waddr = AW'(cursor_r - 1'b1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cursor_r[AW-1:0];
          mem_wdata = {attr_r, char_r};
        end
      end
      OP_COPY: begin
        // Read source cell, write the one read last cycle
        mem_re    = cnt_r < POS_W'(FOLD_CELLS);
        mem_raddr = AW'(cnt_r + POS_W'(FOLD_SRC));
        mem_we    = cnt_r != '0;
        mem_waddr = AW'(cnt_r - 1'b1);
        mem_wdata = mem_rdata;
      end
      OP_BLANK: begin
        mem_we    = blank_pos < (POS_W+1)'(STORE_CELLS);
        mem_waddr = blank_pos[AW-1:0];
      end
      OP_READ: begin
        mem_re    = idx_ok;
        mem_raddr = idx_r[AW-1:0];
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      row_r       <= '0;
      col_r       <= '0;
      view_r      <= '0;
      wrapped_r   <= 1'b0;
      attr_r      <= RESET_ATTR;
      cnt_r       <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_PUT;
    end else begin
      cursor_r  <= cursor_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      view_r    <= view_nxt;
      wrapped_r <= wrapped_nxt;
      if (cfg_we) attr_r <= cfg_wdata;
      if (cmd.latch) mode_r <= mode_t'(in_mode);
      // Sweep counter
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.op == OP_CLEAR || cmd.op == OP_COPY || cmd.op == OP_BLANK) begin
        cnt_r <= cnt_r + 1'b1;
      end
      // Follow step count
      if (cmd.op == OP_PUT) begin
        steps_r <= '0;
      end else if (cmd.op == OP_FOLLOW && !sts.overflow && !sts.follow_exit) begin
        steps_r <= steps_r + 1'b1;
      end
      // Result handshake
      if (cmd.op == OP_RESULT)  out_valid_r <= 1'b1;
      else if (out_ready)       out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      char_r <= in_char_code;
      idx_r  <= in_read_index;
    end
    if (cmd.op == OP_RESULT) begin
      res_cursor_r <= cursor_r;
      res_view_r   <= view_r;
      if (mode_r == MODE_READ && idx_ok) begin
        res_char_r <= mem_rdata[7:0];
        res_attr_r <= mem_rdata[15:8];
      end else begin
        res_char_r <= '0;
        res_attr_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_pos    = res_cursor_r;
  assign out_display_start = res_view_r;
  assign out_read_char     = res_char_r;
  assign out_read_attr     = res_attr_r;

endmodule

>>> tb/sv/text_console_scrollback_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_scrollback_tb
// Drives console commands through the valid/ready channels, predicts cursor,
// view start and read cells with a local console model, and checks every
// result transaction in order. Covers directed corner rows, store folding,
// follow scrolling, view scrolling, attribute changes and output back-pressure.
// ----------------------------------------------------------------------------
module text_console_scrollback_tb;
  import tcs_pkg::*;

  typedef struct {
    logic [12:0] cursor_pos;
    logic [12:0] display_start;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } console_view_t;

  typedef struct {
    mode_t         mode;
    logic [7:0]    ch;
    logic [12:0]   idx;
    bit            typed;
    console_view_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  tcs_in_if  in_ch();
  tcs_out_if out_ch();

  text_console_scrollback u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Console shadow state
  logic [15:0] shadow_cells [STORE_CELLS];
  int          sh_cursor;
  int          sh_view;
  bit          sh_wrapped;
  logic [7:0]  sh_attr;

  console_view_t pending_views[$];
  int  mismatch_count = 0;
  bit  hold_off = 1'b0;
  bit  no_idle = 1'b0;
  int  phase = 0;

  function automatic void shadow_put(int pos, logic [7:0] c);
    if (pos >= 0 && pos < STORE_CELLS) shadow_cells[pos] = {sh_attr, c};
  endfunction

  function automatic void shadow_blank_line(int pos);
    for (int i = 0; i < SCREEN_COLUMNS; i++) shadow_put(pos + i, CH_SPACE);
  endfunction

  function automatic void shadow_view_back();
    sh_view = (sh_view >= SCREEN_COLUMNS) ? sh_view - SCREEN_COLUMNS : 0;
  endfunction

  function automatic void shadow_scroll_fwd();
    int newest;
    newest = sh_cursor / SCREEN_COLUMNS * SCREEN_COLUMNS;
    if (!sh_wrapped) begin
      if (newest >= sh_view + SCREEN_CELLS) sh_view += SCREEN_COLUMNS;
    end else if (sh_view + SCREEN_CELLS - SCREEN_COLUMNS != newest) begin
      if (sh_view + SCREEN_CELLS == STORE_CELLS) sh_view = 0;
      else sh_view += SCREEN_COLUMNS;
    end
  endfunction

  function automatic void shadow_scroll_back();
    int newest;
    int oldest;
    newest = sh_cursor / SCREEN_COLUMNS * SCREEN_COLUMNS;
    oldest = sh_wrapped ? (newest + SCREEN_COLUMNS) % STORE_CELLS : 0;
    if (!sh_wrapped) begin
      if (sh_view > 0) shadow_view_back();
    end else if (sh_view != oldest) begin
      if (sh_cursor >= STORE_CELLS - SCREEN_CELLS) begin
        if (sh_view != 0) shadow_view_back();
      end else if (sh_view == 0) begin
        sh_view = LAST_TOP;
      end else begin
        shadow_view_back();
      end
    end
  endfunction

  function automatic void shadow_fold();
    int col;
    int src;
    col = sh_cursor % SCREEN_COLUMNS;
    src = (sh_cursor / SCREEN_COLUMNS + 1) * SCREEN_COLUMNS - SCREEN_CELLS;
    if (src >= 0) begin
      for (int i = 0; i < FOLD_CELLS; i++)
        if (i < STORE_CELLS && src + i < STORE_CELLS) shadow_cells[i] = shadow_cells[src + i];
    end else begin
      for (int i = FOLD_CELLS - 1; i >= 0; i--)
        if (i < STORE_CELLS && src + i >= 0 && src + i < STORE_CELLS)
          shadow_cells[i] = shadow_cells[src + i];
    end
    sh_view = 0;
    sh_cursor = FOLD_CELLS + col;
    if (sh_cursor >= STORE_CELLS) sh_cursor = STORE_CELLS - 1;
    shadow_blank_line(sh_cursor);
    sh_wrapped = 1'b1;
  endfunction

  function automatic void shadow_put_char(logic [7:0] c);
    int prev;
    if (c == CH_NEWLINE) begin
      sh_cursor = (sh_cursor / SCREEN_COLUMNS + 1) * SCREEN_COLUMNS;
    end else if (c == CH_BACKSPACE) begin
      if (sh_cursor > 0) begin
        sh_cursor--;
        shadow_put(sh_cursor, CH_SPACE);
      end
    end else begin
      shadow_put(sh_cursor, c);
      sh_cursor++;
    end
    if (sh_cursor >= STORE_CELLS) shadow_fold();
    // follow the cursor until it is on screen
    for (int s = 0; s < FOLLOW_STEPS; s++) begin
      prev = sh_view;
      if (sh_cursor < sh_view + SCREEN_CELLS && sh_cursor >= sh_view) break;
      shadow_scroll_fwd();
      if (sh_view == prev) break;
      shadow_blank_line(sh_cursor);
    end
  endfunction

  function automatic console_view_t console_step(mode_t m, logic [7:0] c, logic [12:0] idx);
    console_view_t v;
    v.read_char = 8'd0;
    v.read_attr = 8'd0;
    case (m)
      MODE_PUT:  shadow_put_char(c);
      MODE_FWD:  shadow_scroll_fwd();
      MODE_BACK: shadow_scroll_back();
      default: begin
        if (idx < STORE_CELLS) {v.read_attr, v.read_char} = shadow_cells[idx];
      end
    endcase
    v.cursor_pos = sh_cursor[12:0];
    v.display_start = sh_view[12:0];
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one command and wait for its acceptance
  task automatic send_cmd(mode_t m, logic [7:0] c, logic [12:0] idx,
                          bit typed, console_view_t want);
    int gap;
    console_view_t v;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.char_code <= c;
    in_ch.read_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    v = console_step(m, c, idx);
    pending_views.push_back(typed ? want : v);
  endtask

  task automatic write_attr(logic [7:0] a);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_attr = a;
  endtask

  task automatic send_random();
    int r;
    mode_t m;
    logic [7:0] c;
    logic [12:0] idx;
    console_view_t none;
    none = '{default: '0};
    r = $urandom_range(0, 99);
    m = MODE_PUT;
    c = $urandom_range(0, 255);
    idx = $urandom_range(0, 8191);
    if (r < 30) c = CH_NEWLINE;
    else if (r < 40) c = CH_BACKSPACE;
    else if (r < 50) m = MODE_FWD;
    else if (r < 60) m = MODE_BACK;
    else if (r < 72) begin
      m = MODE_READ;
      if ($urandom_range(0, 9) < 8)
        idx = (r < 67) ? 13'($urandom_range(0, STORE_CELLS - 1))
                       : 13'((sh_cursor + STORE_CELLS - $urandom_range(0, 3)) % STORE_CELLS);
    end
    send_cmd(m, c, idx, 1'b0, none);
  endtask

  // Result checker and receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    console_view_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_views.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result transaction");
        end else begin
          w = pending_views.pop_front();
          if (out_ch.cursor_pos !== w.cursor_pos || out_ch.display_start !== w.display_start ||
              out_ch.read_char !== w.read_char || out_ch.read_attr !== w.read_attr) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp cur %0d start %0d ch %0d at %0d, got %0d %0d %0d %0d",
                       w.cursor_pos, w.display_start, w.read_char, w.read_attr,
                       out_ch.cursor_pos, out_ch.display_start, out_ch.read_char,
                       out_ch.read_attr);
          end
        end
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 25)
          stall_left <= ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 60);
      end
    end
  end

  // Long receiver hold-off while commands keep coming
  initial begin
    wait (phase == 1);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("text_console_scrollback_tb failed");
    $finish;
  end

  stim_row_t directed_rows[] = '{
    '{MODE_READ, 8'd0,         13'd0,    1'b1, '{13'd0,  13'd0, 8'd32,  8'd7}},
    '{MODE_READ, 8'd0,         13'd8191, 1'b1, '{13'd0,  13'd0, 8'd0,   8'd0}},
    '{MODE_READ, 8'd255,       13'd5119, 1'b1, '{13'd0,  13'd0, 8'd32,  8'd7}},
    '{MODE_READ, 8'd0,         13'd5120, 1'b1, '{13'd0,  13'd0, 8'd0,   8'd0}},
    '{MODE_PUT,  CH_BACKSPACE, 13'd0,    1'b1, '{13'd0,  13'd0, 8'd0,   8'd0}},
    '{MODE_FWD,  8'd0,         13'd0,    1'b1, '{13'd0,  13'd0, 8'd0,   8'd0}},
    '{MODE_BACK, 8'd0,         13'd0,    1'b1, '{13'd0,  13'd0, 8'd0,   8'd0}},
    '{MODE_PUT,  8'd255,       13'd0,    1'b1, '{13'd1,  13'd0, 8'd0,   8'd0}},
    '{MODE_PUT,  8'd0,         13'd0,    1'b1, '{13'd2,  13'd0, 8'd0,   8'd0}},
    '{MODE_READ, 8'd0,         13'd0,    1'b1, '{13'd2,  13'd0, 8'd255, 8'd7}},
    '{MODE_PUT,  CH_BACKSPACE, 13'd0,    1'b1, '{13'd1,  13'd0, 8'd0,   8'd0}},
    '{MODE_READ, 8'd0,         13'd1,    1'b1, '{13'd1,  13'd0, 8'd32,  8'd7}},
    '{MODE_PUT,  CH_NEWLINE,   13'd0,    1'b1, '{13'd80, 13'd0, 8'd0,   8'd0}},
    '{MODE_PUT,  8'h41,        13'd0,    1'b0, '{default: '0}},
    '{MODE_READ, 8'd0,         13'd80,   1'b0, '{default: '0}},
    '{MODE_PUT,  8'h7F,        13'd0,    1'b0, '{default: '0}},
    '{MODE_PUT,  8'h80,        13'd0,    1'b0, '{default: '0}},
    '{MODE_FWD,  8'd0,         13'd0,    1'b0, '{default: '0}},
    '{MODE_BACK, 8'd0,         13'd0,    1'b0, '{default: '0}},
    '{MODE_READ, 8'd0,         13'd4095, 1'b0, '{default: '0}},
    '{MODE_READ, 8'd0,         13'd2730, 1'b0, '{default: '0}},
    '{MODE_READ, 8'd0,         13'd5461, 1'b0, '{default: '0}}
  };

  logic [7:0] attr_plan [4] = '{8'd255, 8'd0, 8'h5A, 8'd7};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_PUT;
    in_ch.char_code = 8'd0;
    in_ch.read_index = 13'd0;
    sh_attr = RESET_ATTR;
    sh_cursor = 0;
    sh_view = 0;
    sh_wrapped = 1'b0;
    for (int i = 0; i < STORE_CELLS; i++) shadow_cells[i] = {RESET_ATTR, CH_SPACE};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed corner rows
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].mode, directed_rows[i].ch, directed_rows[i].idx,
               directed_rows[i].typed, directed_rows[i].want);

    // random phases, one attribute setting each; phase 3 runs without idling
    for (int p = 0; p < 4; p++) begin
      write_attr(attr_plan[p]);
      phase = p + 1;
      no_idle = (p == 2);
      repeat (135) send_random();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("text_console_scrollback_tb passed");
    end else begin
      $display("text_console_scrollback_tb failed");
    end
    $finish;
  end

endmodule
